### src/segisect_pkg.sv
// Shared widths, constants and types for the segment intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package segisect_pkg;

   localparam int CW      = 16;          // coordinate width
   localparam int DIFW    = CW + 1;      // endpoint difference width
   localparam int PRODW   = 2 * DIFW;    // product of two differences
   localparam int DENW    = PRODW + 1;   // denominator width
   localparam int NUMW    = PRODW + DIFW + 2; // numerator width
   localparam int QW      = CW + 2;      // quotient bits produced by the divider
   localparam int PW      = QW + 2;      // signed capped quotient width
   localparam int TOLW    = 10;
   localparam int AW      = 3;           // configuration address width
   localparam int DW      = 32;          // configuration data width

   localparam logic [TOLW-1:0] TOL_RESET = TOLW'(1);
   localparam logic [AW-1:0] REG_BOX_TOL = AW'(0);

   localparam int IN_DATA_W  = 8 * CW;
   localparam int OUT_DATA_W = ((2 * CW + 3 + 7) / 8) * 8;

   typedef struct packed {
      logic signed [CW-1:0] lx;
      logic signed [CW-1:0] hx;
      logic signed [CW-1:0] ly;
      logic signed [CW-1:0] hy;
   } box_type;

   // Side information that rides along with the divider stages.
   typedef struct packed {
      logic    infinite;
      logic    par;
      logic    negx;
      logic    negy;
      logic    ovfx;
      logic    ovfy;
      box_type box1;
      box_type box2;
   } side_type;

endpackage
`default_nettype wire

### src/segment_intersection_2d.sv
// Top level: pipelined 2-D line/segment intersection with box test and saturation.
// An accepted word passes through five arithmetic stages, one divider stage per
// quotient bit (18) and one output register before its result word appears.
// Throughput is one word per cycle; the whole pipeline advances together and
// holds while a result word waits at the output.
// Reset clears all valid bits and sets box_tolerance to 1.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_2d (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // first_ax, first_ay, first_bx, first_by, second_ax, second_ay, second_bx, second_by
   input  wire logic [segisect_pkg::IN_DATA_W-1:0] req_tdata,
   // operation
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // hit, parallel, cross_x, cross_y, saturated, zero fill
   output logic [segisect_pkg::OUT_DATA_W-1:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [segisect_pkg::AW-1:0] csr_paddr,
   input  wire logic [segisect_pkg::DW-1:0] csr_pwdata,
   output logic [segisect_pkg::DW-1:0] csr_prdata,
   output logic             csr_pready
);

   localparam int CW    = segisect_pkg::CW;
   localparam int DIFW  = segisect_pkg::DIFW;
   localparam int PRODW = segisect_pkg::PRODW;
   localparam int DENW  = segisect_pkg::DENW;
   localparam int NUMW  = segisect_pkg::NUMW;
   localparam int QW    = segisect_pkg::QW;
   localparam int PW    = segisect_pkg::PW;
   localparam int TOLW  = segisect_pkg::TOLW;

   // ---------------- configuration ----------------
   logic [TOLW-1:0] tol_ff, tol_in;

   assign csr_pready = 1'b1;
   always_comb begin
      tol_in = tol_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr == segisect_pkg::REG_BOX_TOL) begin
         tol_in = csr_pwdata[TOLW-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr == segisect_pkg::REG_BOX_TOL) begin
         csr_prdata = segisect_pkg::DW'(tol_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= segisect_pkg::TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic signed [CW-1:0] in_ax1, in_ay1, in_bx1, in_by1, in_ax2, in_ay2, in_bx2, in_by2;
   assign in_ax1 = req_tdata[0*CW +: CW];
   assign in_ay1 = req_tdata[1*CW +: CW];
   assign in_bx1 = req_tdata[2*CW +: CW];
   assign in_by1 = req_tdata[3*CW +: CW];
   assign in_ax2 = req_tdata[4*CW +: CW];
   assign in_ay2 = req_tdata[5*CW +: CW];
   assign in_bx2 = req_tdata[6*CW +: CW];
   assign in_by2 = req_tdata[7*CW +: CW];

   // ---------------- stage 1: differences and boxes ----------------
   logic v1_ff;
   logic signed [DIFW-1:0] a1_ff, b1_ff, d1_ff, e1_ff, dx1_ff, dy1_ff;
   logic signed [CW-1:0] ax1_1_ff, ay1_1_ff, ax2_1_ff, ay2_1_ff;
   segisect_pkg::box_type box1_1_ff, box2_1_ff, box1_in, box2_in;
   logic inf1_ff;

   always_comb begin
      box1_in.lx = (in_ax1 < in_bx1) ? in_ax1 : in_bx1;
      box1_in.hx = (in_ax1 < in_bx1) ? in_bx1 : in_ax1;
      box1_in.ly = (in_ay1 < in_by1) ? in_ay1 : in_by1;
      box1_in.hy = (in_ay1 < in_by1) ? in_by1 : in_ay1;
      box2_in.lx = (in_ax2 < in_bx2) ? in_ax2 : in_bx2;
      box2_in.hx = (in_ax2 < in_bx2) ? in_bx2 : in_ax2;
      box2_in.ly = (in_ay2 < in_by2) ? in_ay2 : in_by2;
      box2_in.hy = (in_ay2 < in_by2) ? in_by2 : in_ay2;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff     <= DIFW'(in_by1) - DIFW'(in_ay1);
         b1_ff     <= DIFW'(in_bx1) - DIFW'(in_ax1);
         d1_ff     <= DIFW'(in_by2) - DIFW'(in_ay2);
         e1_ff     <= DIFW'(in_bx2) - DIFW'(in_ax2);
         dx1_ff    <= DIFW'(in_ax2) - DIFW'(in_ax1);
         dy1_ff    <= DIFW'(in_ay2) - DIFW'(in_ay1);
         ax1_1_ff  <= in_ax1;
         ay1_1_ff  <= in_ay1;
         ax2_1_ff  <= in_ax2;
         ay2_1_ff  <= in_ay2;
         box1_1_ff <= box1_in;
         box2_1_ff <= box2_in;
         inf1_ff   <= req_tuser[0];
      end
   end

   // ---------------- stage 2: pairwise products ----------------
   logic v2_ff;
   logic signed [PRODW-1:0] ae2_ff, db2_ff, be2_ff, ad2_ff;
   logic signed [DIFW-1:0] dx2_ff, dy2_ff;
   logic signed [CW-1:0] ax1_2_ff, ay1_2_ff, ax2_2_ff, ay2_2_ff;
   segisect_pkg::box_type box1_2_ff, box2_2_ff;
   logic inf2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ae2_ff    <= PRODW'(a1_ff) * PRODW'(e1_ff);
         db2_ff    <= PRODW'(d1_ff) * PRODW'(b1_ff);
         be2_ff    <= PRODW'(b1_ff) * PRODW'(e1_ff);
         ad2_ff    <= PRODW'(a1_ff) * PRODW'(d1_ff);
         dx2_ff    <= dx1_ff;
         dy2_ff    <= dy1_ff;
         ax1_2_ff  <= ax1_1_ff;
         ay1_2_ff  <= ay1_1_ff;
         ax2_2_ff  <= ax2_1_ff;
         ay2_2_ff  <= ay2_1_ff;
         box1_2_ff <= box1_1_ff;
         box2_2_ff <= box2_1_ff;
         inf2_ff   <= inf1_ff;
      end
   end

   // ---------------- stage 3: numerator terms and denominator ----------------
   // nx = AE*ax1 - DB*ax2 + BE*(ay2-ay1), ny = DB*ay1 - AE*ay2 + AD*(ax2-ax1)
   logic v3_ff;
   logic signed [NUMW-1:0] t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   logic signed [DENW-1:0] den3_ff;
   segisect_pkg::box_type box1_3_ff, box2_3_ff;
   logic inf3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff     <= NUMW'(ae2_ff) * NUMW'(ax1_2_ff);
         t2_ff     <= NUMW'(db2_ff) * NUMW'(ax2_2_ff);
         t3_ff     <= NUMW'(be2_ff) * NUMW'(dy2_ff);
         t4_ff     <= NUMW'(db2_ff) * NUMW'(ay1_2_ff);
         t5_ff     <= NUMW'(ae2_ff) * NUMW'(ay2_2_ff);
         t6_ff     <= NUMW'(ad2_ff) * NUMW'(dx2_ff);
         den3_ff   <= DENW'(ae2_ff) - DENW'(db2_ff);
         box1_3_ff <= box1_2_ff;
         box2_3_ff <= box2_2_ff;
         inf3_ff   <= inf2_ff;
      end
   end

   // ---------------- stage 4: numerator sums ----------------
   logic v4_ff;
   logic signed [NUMW-1:0] nx4_ff, ny4_ff;
   logic signed [DENW-1:0] den4_ff;
   segisect_pkg::box_type box1_4_ff, box2_4_ff;
   logic inf4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         nx4_ff    <= t1_ff - t2_ff + t3_ff;
         ny4_ff    <= t4_ff - t5_ff + t6_ff;
         den4_ff   <= den3_ff;
         box1_4_ff <= box1_3_ff;
         box2_4_ff <= box2_3_ff;
         inf4_ff   <= inf3_ff;
      end
   end

   // ---------------- stage 5: magnitudes, signs, range check ----------------
   logic [NUMW-1:0] unx, uny, udw;
   logic dneg;

   assign dneg = den4_ff[DENW-1];
   assign unx  = nx4_ff[NUMW-1] ? NUMW'(-nx4_ff) : NUMW'(nx4_ff);
   assign uny  = ny4_ff[NUMW-1] ? NUMW'(-ny4_ff) : NUMW'(ny4_ff);
   assign udw  = dneg ? NUMW'(-NUMW'(den4_ff)) : NUMW'(den4_ff);

   // Divider chain: index 0 is the stage 5 output, index k+1 has resolved
   // quotient bit QW-1-k.
   logic                   dv_ff   [0:QW];
   logic [NUMW-1:0]        rx_ff   [0:QW];
   logic [NUMW-1:0]        ry_ff   [0:QW];
   logic [QW-1:0]          qx_ff   [0:QW];
   logic [QW-1:0]          qy_ff   [0:QW];
   logic [DENW-1:0]        ud_ff   [0:QW];
   segisect_pkg::side_type side_ff [0:QW];
   segisect_pkg::side_type side_in;

   always_comb begin
      side_in.infinite = inf4_ff;
      side_in.par      = (den4_ff == '0);
      // The y quotient divides by -den, so its divisor sign is flipped.
      side_in.negx     = nx4_ff[NUMW-1] ^ dneg;
      side_in.negy     = ny4_ff[NUMW-1] ^ !dneg;
      side_in.ovfx     = unx >= (udw << QW);
      side_in.ovfy     = uny >= (udw << QW);
      side_in.box1     = box1_4_ff;
      side_in.box2     = box2_4_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff[0]   <= unx;
         ry_ff[0]   <= uny;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         ud_ff[0]   <= udw[DENW-1:0];
         side_ff[0] <= side_in;
         for (int k = 0; k < QW; k++) begin
            logic [NUMW-1:0] trial;
            trial = NUMW'(ud_ff[k]) << (QW - 1 - k);
            if (rx_ff[k] >= trial) begin
               rx_ff[k+1] <= rx_ff[k] - trial;
               qx_ff[k+1] <= qx_ff[k] | (QW'(1) << (QW - 1 - k));
            end else begin
               rx_ff[k+1] <= rx_ff[k];
               qx_ff[k+1] <= qx_ff[k];
            end
            if (ry_ff[k] >= trial) begin
               ry_ff[k+1] <= ry_ff[k] - trial;
               qy_ff[k+1] <= qy_ff[k] | (QW'(1) << (QW - 1 - k));
            end else begin
               ry_ff[k+1] <= ry_ff[k];
               qy_ff[k+1] <= qy_ff[k];
            end
            ud_ff[k+1]   <= ud_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // ---------------- valid chain ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int k = 0; k <= QW; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff    <= req_tvalid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         dv_ff[0] <= v4_ff;
         for (int k = 0; k < QW; k++) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end
   end

   // ---------------- output stage: sign, box test, clipping ----------------
   segisect_pkg::side_type sf;
   logic [PW-1:0] magx, magy;
   logic signed [PW-1:0] px, py, tolw;
   logic in_box1, in_box2, hit_in, satx, saty;
   logic signed [CW-1:0] cx_in, cy_in;
   localparam logic signed [PW-1:0] CLIP_HI = PW'((1 << (CW - 1)) - 1);
   localparam logic signed [PW-1:0] CLIP_LO = -CLIP_HI - PW'(1);

   always_comb begin
      sf   = side_ff[QW];
      // An out-of-range quotient is capped just past the quotient range.
      magx = sf.ovfx ? (PW'(1) << QW) : PW'(qx_ff[QW]);
      magy = sf.ovfy ? (PW'(1) << QW) : PW'(qy_ff[QW]);
      px   = sf.negx ? -$signed(magx) : $signed(magx);
      py   = sf.negy ? -$signed(magy) : $signed(magy);
      tolw = $signed(PW'(tol_ff));
      in_box1 = (PW'(sf.box1.lx) - tolw <= px) && (PW'(sf.box1.ly) - tolw <= py) &&
                (px <= PW'(sf.box1.hx) + tolw) && (py <= PW'(sf.box1.hy) + tolw);
      in_box2 = (PW'(sf.box2.lx) - tolw <= px) && (PW'(sf.box2.ly) - tolw <= py) &&
                (px <= PW'(sf.box2.hx) + tolw) && (py <= PW'(sf.box2.hy) + tolw);
      hit_in  = in_box2 && (sf.infinite || in_box1);
      satx = 1'b1;
      saty = 1'b1;
      if (px > CLIP_HI) begin
         cx_in = CLIP_HI[CW-1:0];
      end else if (px < CLIP_LO) begin
         cx_in = CLIP_LO[CW-1:0];
      end else begin
         cx_in = px[CW-1:0];
         satx  = 1'b0;
      end
      if (py > CLIP_HI) begin
         cy_in = CLIP_HI[CW-1:0];
      end else if (py < CLIP_LO) begin
         cy_in = CLIP_LO[CW-1:0];
      end else begin
         cy_in = py[CW-1:0];
         saty  = 1'b0;
      end
   end

   logic out_v_ff;
   logic hit_ff, par_ff, sat_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         par_ff <= sf.par;
         if (sf.par) begin
            hit_ff <= 1'b0;
            cx_ff  <= '0;
            cy_ff  <= '0;
            sat_ff <= 1'b0;
         end else begin
            hit_ff <= hit_in;
            cx_ff  <= cx_in;
            cy_ff  <= cy_in;
            sat_ff <= satx || saty;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = segisect_pkg::OUT_DATA_W'({sat_ff, cy_ff, cx_ff, par_ff, hit_ff});

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the segment intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   localparam int CW         = segisect_pkg::CW;
   localparam int TOLW       = segisect_pkg::TOLW;
   localparam int AW         = segisect_pkg::AW;
   localparam int DW         = segisect_pkg::DW;
   localparam int IN_DATA_W  = segisect_pkg::IN_DATA_W;
   localparam int OUT_DATA_W = segisect_pkg::OUT_DATA_W;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_DATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [AW-1:0] csr_paddr = '0;
   logic [DW-1:0] csr_pwdata = '0;
   logic [DW-1:0] csr_prdata;
   logic csr_pready;

   segment_intersection_2d dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [TOLW-1:0] tolerance_shadow = segisect_pkg::TOL_RESET;
   logic [OUT_DATA_W-1:0] pending_points[$];
   int failures = 0;
   int send_idle_pct = 0;
   int sink_idle_pct = 0;
   int sink_hold_left = 0;
   int quiet_cycles = 0;

   function automatic longint cap_quotient(longint q);
      longint lim;
      lim = 64'sd1 << 40;
      if (q > lim) return lim;
      if (q < -lim) return -lim;
      return q;
   endfunction

   function automatic bit within_box(longint px, longint py, longint ax, longint ay,
                                     longint bx, longint by, longint tol);
      longint lx, hx, ly, hy;
      lx = (ax < bx) ? ax : bx;
      hx = (ax < bx) ? bx : ax;
      ly = (ay < by) ? ay : by;
      hy = (ay < by) ? by : ay;
      return (lx - tol <= px) && (ly - tol <= py) && (px <= hx + tol) && (py <= hy + tol);
   endfunction

   function automatic logic [CW-1:0] clip_coord(longint v, ref bit sat);
      if (v > 32767) begin
         sat = 1'b1;
         return 16'h7fff;
      end
      if (v < -32768) begin
         sat = 1'b1;
         return 16'h8000;
      end
      return v[CW-1:0];
   endfunction

   // Packs the expected result word in the same layout as rsp_tdata.
   function automatic logic [OUT_DATA_W-1:0] predict_crossing(logic [IN_DATA_W-1:0] pts,
                                                              logic infinite);
      longint p[8];
      longint a, b, d, e, den, nx, ny, qx, qy, tol;
      bit hit, sat;
      logic [CW-1:0] cx, cy;
      for (int i = 0; i < 8; i++) p[i] = longint'($signed(pts[CW*i +: CW]));
      a = p[3] - p[1];
      b = p[2] - p[0];
      d = p[7] - p[5];
      e = p[6] - p[4];
      den = a * e - d * b;
      if (den == 0) return {{(OUT_DATA_W-2){1'b0}}, 1'b1, 1'b0};
      nx = a * e * p[0] - b * e * p[1] - d * b * p[4] + b * e * p[5];
      ny = b * d * p[1] - a * d * p[0] - e * a * p[5] + a * d * p[4];
      qx = cap_quotient(nx / den);
      qy = cap_quotient(ny / (-den));
      tol = longint'(tolerance_shadow);
      hit = within_box(qx, qy, p[4], p[5], p[6], p[7], tol);
      if (!infinite) hit = hit && within_box(qx, qy, p[0], p[1], p[2], p[3], tol);
      sat = 1'b0;
      cx = clip_coord(qx, sat);
      cy = clip_coord(qy, sat);
      return {{(OUT_DATA_W-35){1'b0}}, sat, cy, cx, 1'b0, hit};
   endfunction

   task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      logic [OUT_DATA_W-1:0] exp_word;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pending_points.push_back(predict_crossing(req_tdata, req_tuser[0]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_points.size() == 0) begin
               $error("result word with nothing expected: %h", rsp_tdata);
               failures++;
            end else begin
               exp_word = pending_points.pop_front();
               compare_field("hit", 32'(exp_word[0]), 32'(rsp_tdata[0]));
               compare_field("parallel", 32'(exp_word[1]), 32'(rsp_tdata[1]));
               compare_field("cross_x", 32'(exp_word[17:2]), 32'(rsp_tdata[17:2]));
               compare_field("cross_y", 32'(exp_word[33:18]), 32'(rsp_tdata[33:18]));
               compare_field("saturated", 32'(exp_word[34]), 32'(rsp_tdata[34]));
               compare_field("fill", 32'(exp_word[OUT_DATA_W-1:35]),
                             32'(rsp_tdata[OUT_DATA_W-1:35]));
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (!reset) begin
         if (sink_hold_left > 0) begin
            sink_hold_left = sink_hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[segment_intersection_2d] ERROR");
         $finish;
      end
   end

   task automatic send_word(logic op, logic signed [CW-1:0] c[8]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      for (int i = 0; i < 8; i++) req_tdata[CW*i +: CW] <= c[i];
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_pair(int op, int ax1, int ay1, int bx1, int by1,
                            int ax2, int ay2, int bx2, int by2);
      logic signed [CW-1:0] c[8];
      c = '{ax1[CW-1:0], ay1[CW-1:0], bx1[CW-1:0], by1[CW-1:0],
            ax2[CW-1:0], ay2[CW-1:0], bx2[CW-1:0], by2[CW-1:0]};
      send_word(op[0], c);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write_read(logic [TOLW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= AW'(4 * segisect_pkg::REG_BOX_TOL);
      csr_pwdata <= DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tolerance_shadow = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      compare_field("box_tolerance", DW'(value), csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_value();
      csr_psel <= 1'b1;
      csr_paddr <= AW'(4 * segisect_pkg::REG_BOX_TOL);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      compare_field("box_tolerance", DW'(segisect_pkg::TOL_RESET), csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      // Plain crossing at the origin, for both operations.
      send_pair(0, -256, -256, 256, 256, -256, 256, 256, -256);
      send_pair(1, -256, -256, 256, 256, -256, 256, 256, -256);
      // Crossing outside the first segment: only the infinite form hits.
      send_pair(0, 512, 512, 768, 768, -256, 256, 256, -256);
      send_pair(1, 512, 512, 768, 768, -256, 256, 256, -256);
      // Parallel lines and a segment of zero length.
      send_pair(0, 0, 0, 100, 100, 10, 0, 110, 100);
      send_pair(0, 5, 5, 5, 5, -256, 256, 256, -256);
      send_pair(1, 0, 0, 0, 0, 0, 0, 0, 0);
      // Point just beyond an endpoint: inside or outside depending on tolerance.
      send_pair(0, 0, 0, 100, 0, 101, -50, 101, 50);
      send_pair(0, 0, 0, 100, 0, 102, -50, 102, 50);
      // Extreme endpoints and near-parallel lines that saturate.
      send_pair(0, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      send_pair(1, 32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
      send_pair(1, 0, 0, 32767, 1, 0, 1, 32767, 3);
      send_pair(1, 0, 0, 32767, 1, 0, -1, 32767, -3);
      send_pair(1, 0, 0, 1, 32767, 1, 0, 3, 32767);
      send_pair(1, 0, 0, 1, 32767, -1, 0, -3, 32767);
      send_pair(0, -32768, 0, 32767, 0, 0, -32768, 0, 32767);
      wait_drained();
   endtask

   // Mostly pairs built around a shared point, some of them parallel, the rest unrelated.
   task automatic test_random_pairs(int count);
      int kind, cx, cy, dx1, dy1, dx2, dy2, off;
      logic signed [CW-1:0] c[8];
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         cx = $urandom_range(40000) - 20000;
         cy = $urandom_range(40000) - 20000;
         dx1 = $urandom_range(12000) - 6000;
         dy1 = $urandom_range(12000) - 6000;
         dx2 = $urandom_range(12000) - 6000;
         dy2 = $urandom_range(12000) - 6000;
         off = $urandom_range(8) - 4;
         if (kind < 15) begin
            dx2 = 2 * dx1;
            dy2 = 2 * dy1;
         end
         if (kind < 75) begin
            send_pair($urandom_range(1), cx + dx1 + off, cy + dy1, cx - dx1, cy - dy1 - off,
                      cx + dx2, cy + dy2 + off, cx - dx2 - off, cy - dy2);
         end else begin
            for (int i = 0; i < 8; i++) c[i] = CW'($urandom_range(16'hffff));
            send_word(1'($urandom_range(1)), c);
         end
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      sink_hold_left = 300;
      test_random_pairs(60);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_directed();
      csr_write_read(TOLW'(0));
      test_directed();
      csr_write_read(TOLW'(1023));
      test_directed();
      send_idle_pct = 27;
      sink_idle_pct = 62;
      csr_write_read(TOLW'($urandom_range(1023)));
      test_random_pairs(110);
      send_idle_pct = 62;
      sink_idle_pct = 27;
      csr_write_read(TOLW'(1));
      test_random_pairs(110);
      send_idle_pct = 0;
      sink_idle_pct = 0;
      csr_write_read(TOLW'($urandom_range(40)));
      test_random_pairs(110);
      test_backpressure();
      if (failures == 0) $display("[segment_intersection_2d] OK");
      else $display("[segment_intersection_2d] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
